### design/conv3x3_stream_macros.svh
// Assertion macros shared by the conv3x3_stream modules.
`ifndef CONV3X3_STREAM_MACROS_SVH
`define CONV3X3_STREAM_MACROS_SVH

// Same-cycle implication, checked outside reset
`define C3S_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("conv3x3_stream assertion failed");

// Next-cycle implication, checked outside reset
`define C3S_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("conv3x3_stream assertion failed");

`endif

### design/c3s_pkg.sv
// Shared constants and types of the 3x3 streaming convolution block.
`timescale 1ns / 1ps

package c3s_pkg;

    localparam int MAX_LINE      = 1024;
    localparam int PIXEL_BITS    = 16;
    localparam int COEF_BITS     = 16;
    localparam int PROD_BITS     = PIXEL_BITS + COEF_BITS;
    localparam int SUM_BITS      = 36;
    localparam int ADDR_BITS     = $clog2(MAX_LINE);
    localparam int WIDTH_BITS    = 11;
    localparam int HEIGHT_BITS   = 13;
    localparam int ROW_BITS      = 12;
    localparam int HEIGHT_MAX    = 4096;
    localparam int KROW_BITS     = 3 * COEF_BITS;
    localparam int CFG_ADDR_BITS = 3;
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int SDATA_BITS    = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int MDATA_BITS    = ((SUM_BITS + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_KERNEL_TOP    = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_KERNEL_MID    = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_KERNEL_BOTTOM = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LINE_WIDTH    = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_FRAME_HEIGHT  = 3'd4;

    typedef logic signed [PIXEL_BITS-1:0] pix_t;

    // Three kernel rows, row 0 at index 0, column 0 in the low bits of each
    typedef logic [2:0][KROW_BITS-1:0] kernel_t;

    // Complete 3x3 window handed to the MAC pipeline
    typedef struct packed {
        logic            valid;
        logic            last;
        pix_t [8:0]      px;
    } win_t;

    typedef struct packed {
        logic                       last;
        logic signed [SUM_BITS-1:0] sum;
    } result_t;

endpackage

### design/c3s_ram.sv
// Generic simple dual-port RAM with registered read (read-first on collision).
`timescale 1ns / 1ps

module c3s_ram #(
    parameter int DATA_BITS = 16,
    parameter int DEPTH     = 1024,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/c3s_window.sv
// Raster position tracking, line-store read-modify-write and 3x3 window registers.
`timescale 1ns / 1ps
`include "conv3x3_stream_macros.svh"

module c3s_window import c3s_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   acc,
    input  pix_t                   pixel,
    input  logic                   frame_start,
    input  logic [WIDTH_BITS-1:0]  line_width,
    input  logic [HEIGHT_BITS-1:0] frame_height,
    output logic                   acc_emit,
    output win_t                   win
);

    logic [WIDTH_BITS-1:0]  w_eff, w_last;
    logic [HEIGHT_BITS-1:0] h_eff, h_last;
    logic [ADDR_BITS-1:0]   col_cur, col_a;
    logic [ROW_BITS-1:0]    row_cur;
    logic                   at_eol, at_eof;

    logic [ADDR_BITS-1:0]   col_reg, col_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;

    logic                   s1_valid_reg, s1_emit_reg, s1_last_reg;
    logic [ADDR_BITS-1:0]   s1_addr_reg;
    pix_t                   s1_pix_reg;

    logic                   fwd_reg;
    pix_t                   fwd_lo_reg, fwd_p_reg;

    logic [PIXEL_BITS-1:0]  ram_up, ram_lo;
    pix_t                   up_eff, lo_eff;

    pix_t                   win_reg [9];
    logic                   win_valid_reg, win_last_reg;

    // Clamp geometry to the supported range
    always_comb begin
        priority if (line_width < WIDTH_BITS'(3)) begin
            w_eff = WIDTH_BITS'(3);
        end else if (line_width > WIDTH_BITS'(MAX_LINE)) begin
            w_eff = WIDTH_BITS'(MAX_LINE);
        end else begin
            w_eff = line_width;
        end
        priority if (frame_height < HEIGHT_BITS'(3)) begin
            h_eff = HEIGHT_BITS'(3);
        end else if (frame_height > HEIGHT_BITS'(HEIGHT_MAX)) begin
            h_eff = HEIGHT_BITS'(HEIGHT_MAX);
        end else begin
            h_eff = frame_height;
        end
        w_last = w_eff - WIDTH_BITS'(1);
        h_last = h_eff - HEIGHT_BITS'(1);
    end

    // Position of the incoming beat
    always_comb begin
        col_cur = frame_start ? '0 : col_reg;
        row_cur = frame_start ? '0 : row_reg;
        col_a   = (WIDTH_BITS'(col_cur) >= w_eff) ? w_last[ADDR_BITS-1:0] : col_cur;
        at_eol  = (WIDTH_BITS'(col_a) >= w_last);
        at_eof  = at_eol && (HEIGHT_BITS'(row_cur) >= h_last);
        acc_emit = (row_cur >= ROW_BITS'(2)) && (col_a >= ADDR_BITS'(2));
    end

    // Next position
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (acc) begin
            priority if (at_eof) begin
                col_next = '0;
                row_next = '0;
            end else if (at_eol) begin
                col_next = '0;
                row_next = row_cur + ROW_BITS'(1);
            end else begin
                col_next = col_a + ADDR_BITS'(1);
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1: beat waits for the line-store read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            s1_valid_reg <= acc;
            // back-to-back access to one column: the RAM returns the pre-write data
            fwd_reg      <= acc && s1_valid_reg && (col_a == s1_addr_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_addr_reg <= col_a;
            s1_pix_reg  <= pixel;
            s1_emit_reg <= acc_emit;
            s1_last_reg <= at_eof;
        end
        fwd_lo_reg <= lo_eff;
        fwd_p_reg  <= s1_pix_reg;
    end

    assign up_eff = fwd_reg ? fwd_lo_reg : pix_t'(ram_up);
    assign lo_eff = fwd_reg ? fwd_p_reg  : pix_t'(ram_lo);

    // Line stores: upper holds row r-2, lower row r-1
    c3s_ram #(
        .DATA_BITS (PIXEL_BITS),
        .DEPTH     (MAX_LINE)
    ) u_line_upper (
        .clk     (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (lo_eff),
        .rd_en   (acc),
        .rd_addr (col_a),
        .rd_data (ram_up)
    );

    c3s_ram #(
        .DATA_BITS (PIXEL_BITS),
        .DEPTH     (MAX_LINE)
    ) u_line_lower (
        .clk     (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_pix_reg),
        .rd_en   (acc),
        .rd_addr (col_a),
        .rd_data (ram_lo)
    );

    // Window shift: newest column enters at the right
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
            win_valid_reg <= 1'b0;
        end else begin
            win_valid_reg <= s1_valid_reg && s1_emit_reg;
            if (s1_valid_reg) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[r*3]     <= win_reg[r*3 + 1];
                    win_reg[r*3 + 1] <= win_reg[r*3 + 2];
                end
                win_reg[2] <= up_eff;
                win_reg[5] <= lo_eff;
                win_reg[8] <= s1_pix_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            win_last_reg <= s1_last_reg;
        end
    end

    always_comb begin
        win.valid = win_valid_reg;
        win.last  = win_last_reg;
        for (int i = 0; i < 9; i++) begin
            win.px[i] = win_reg[i];
        end
    end

    `C3S_ASSERT_IMPL(a_col_in_line, aclk, aresetn, acc, WIDTH_BITS'(col_a) < w_eff)
    `C3S_ASSERT_NEXT(a_win_follows_emit, aclk, aresetn, s1_valid_reg && s1_emit_reg, win.valid)

endmodule

### design/c3s_mac.sv
// Nine-tap multiply and adder tree over the 3x3 window.
`timescale 1ns / 1ps

module c3s_mac import c3s_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  win_t    win,
    input  kernel_t kern,
    output logic    res_valid,
    output result_t res
);

    logic signed [COEF_BITS-1:0] coef_w [9];
    logic signed [PROD_BITS-1:0] prod_w [9];
    logic signed [PROD_BITS-1:0] prod_reg [9];
    logic signed [SUM_BITS-1:0]  part_reg [3];
    logic signed [SUM_BITS-1:0]  sum_reg;
    logic                        p_valid_reg, a_valid_reg, f_valid_reg;
    logic                        p_last_reg, a_last_reg, f_last_reg;

    // Products, one per tap
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef_w[r*3 + c] = signed'(kern[r][c*COEF_BITS +: COEF_BITS]);
                prod_w[r*3 + c] = coef_w[r*3 + c] * win.px[r*3 + c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= win.valid;
            a_valid_reg <= p_valid_reg;
            f_valid_reg <= a_valid_reg;
        end
    end

    // Product stage, row sums, final sum
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 9; i++) begin
            prod_reg[i] <= prod_w[i];
        end
        p_last_reg <= win.last;
        for (int r = 0; r < 3; r++) begin
            part_reg[r] <= SUM_BITS'(prod_reg[r*3]) + SUM_BITS'(prod_reg[r*3 + 1])
                         + SUM_BITS'(prod_reg[r*3 + 2]);
        end
        a_last_reg <= p_last_reg;
        sum_reg    <= part_reg[0] + part_reg[1] + part_reg[2];
        f_last_reg <= a_last_reg;
    end

    assign res_valid = f_valid_reg;
    assign res.sum   = sum_reg;
    assign res.last  = f_last_reg;

endmodule

### design/c3s_ofifo.sv
// Output queue that decouples the MAC pipeline from result backpressure.
`timescale 1ns / 1ps
`include "conv3x3_stream_macros.svh"

module c3s_ofifo import c3s_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   wr_en,
    input  result_t                wr_data,
    output logic                   rd_valid,
    input  logic                   rd_ready,
    output result_t                rd_data,
    output logic [FIFO_PTR_BITS:0] count
);

    result_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_PTR_BITS:0]   count_reg, count_next;
    logic                     rd_en;

    assign rd_valid = (count_reg != '0);
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];
    assign count    = count_reg;

    always_comb begin
        count_next = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + (FIFO_PTR_BITS+1)'(1);
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - (FIFO_PTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_BITS'(1);
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    `C3S_ASSERT_IMPL(a_no_overflow, aclk, aresetn, wr_en, count_reg < (FIFO_PTR_BITS+1)'(FIFO_DEPTH))

endmodule

### design/conv3x3_stream.sv
// Top level of the streaming 3x3 convolution: config registers, flow control, submodules.
`timescale 1ns / 1ps
`include "conv3x3_stream_macros.svh"

// conv3x3_stream takes one signed Q8.8 pixel per beat in raster order and, for
// every position where the 3x3 window lies fully inside the frame, returns the
// exact 36-bit correlation sum of the window with the programmed kernel; the
// final window of a frame carries tlast. It sustains one pixel per clock: the
// pace is set by the two line-store RAMs, which take one read and one
// write-back of a single column each cycle. A result moves from the pixel that
// completes its window through the stage-1, window, product, row-sum and final-sum
// registers into an eight-beat output queue that takes up backpressure; once eight
// results are queued or in flight, s_tready drops. The line stores need no
// clearing after reset. Program the kernel and geometry only while the block is idle.
module conv3x3_stream import c3s_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_wen,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [KROW_BITS-1:0]     cfg_wdata,
    // pixel input
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [SDATA_BITS-1:0]    s_tdata,   // [15:0] pixel
    input  logic                     s_tuser,   // [0] frame_start
    // result output
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [MDATA_BITS-1:0]    m_tdata,   // [35:0] window_sum, rest zero
    output logic                     m_tlast
);

    logic [KROW_BITS-1:0]   k_top_reg, k_mid_reg, k_bot_reg;
    logic [WIDTH_BITS-1:0]  line_width_reg;
    logic [HEIGHT_BITS-1:0] frame_height_reg;
    kernel_t                kern;

    logic                   acc, acc_emit, out_fire;
    logic [FIFO_PTR_BITS:0] credit_reg, credit_next, fifo_count;
    win_t                   win;
    logic                   res_valid;
    result_t                res, out_res;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_top_reg        <= '0;
            k_mid_reg        <= '0;
            k_bot_reg        <= '0;
            line_width_reg   <= WIDTH_BITS'(1024);
            frame_height_reg <= HEIGHT_BITS'(3);
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                REG_KERNEL_TOP:    k_top_reg        <= cfg_wdata;
                REG_KERNEL_MID:    k_mid_reg        <= cfg_wdata;
                REG_KERNEL_BOTTOM: k_bot_reg        <= cfg_wdata;
                REG_LINE_WIDTH:    line_width_reg   <= cfg_wdata[WIDTH_BITS-1:0];
                REG_FRAME_HEIGHT:  frame_height_reg <= cfg_wdata[HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign kern[0] = k_top_reg;
    assign kern[1] = k_mid_reg;
    assign kern[2] = k_bot_reg;

    // Credits: results accepted but not yet delivered never exceed the queue depth
    assign s_tready = (credit_reg < (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
    assign acc      = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    always_comb begin
        credit_next = credit_reg;
        if ((acc && acc_emit) && !out_fire) begin
            credit_next = credit_reg + (FIFO_PTR_BITS+1)'(1);
        end else if (out_fire && !(acc && acc_emit)) begin
            credit_next = credit_reg - (FIFO_PTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
        end
    end

    c3s_window u_window (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .acc          (acc),
        .pixel        (pix_t'(s_tdata[PIXEL_BITS-1:0])),
        .frame_start  (s_tuser),
        .line_width   (line_width_reg),
        .frame_height (frame_height_reg),
        .acc_emit     (acc_emit),
        .win          (win)
    );

    c3s_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .win       (win),
        .kern      (kern),
        .res_valid (res_valid),
        .res       (res)
    );

    c3s_ofifo u_ofifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (res_valid),
        .wr_data  (res),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (out_res),
        .count    (fifo_count)
    );

    assign m_tdata = {{(MDATA_BITS-SUM_BITS){1'b0}}, out_res.sum};
    assign m_tlast = out_res.last;

    `C3S_ASSERT_IMPL(a_queue_within_credit, aclk, aresetn, 1'b1, fifo_count <= credit_reg)

endmodule

### tb/tb_top.sv
// Self-checking testbench for conv3x3_stream: directed frames and random frames.
`timescale 1ns / 1ps

module tb_top;
    import c3s_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASE_ITEMS    = 250;
    localparam int MAX_REPORTS    = 50;

    // Tracks the window state and queues the sums and tlast flags the block owes
    class conv_window_tracker;
        logic signed [COEF_BITS-1:0] coef [3][3];
        int unsigned width_reg;
        int unsigned height_reg;
        pix_t        upper_line [MAX_LINE];
        pix_t        lower_line [MAX_LINE];
        pix_t        win [3][3];
        int unsigned col_cnt;
        int unsigned row_cnt;
        result_t     sums_due [$];
        int          errors;

        function new();
            foreach (coef[i, j]) coef[i][j] = '0;
            foreach (win[i, j]) win[i][j] = '0;
            foreach (upper_line[i]) upper_line[i] = '0;
            foreach (lower_line[i]) lower_line[i] = '0;
            width_reg  = MAX_LINE;
            height_reg = 3;
            col_cnt    = 0;
            row_cnt    = 0;
            errors     = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg < 3) return 3;
            if (width_reg > MAX_LINE) return MAX_LINE;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg < 3) return 3;
            if (height_reg > HEIGHT_MAX) return HEIGHT_MAX;
            return height_reg;
        endfunction

        function void set_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                              input logic [KROW_BITS-1:0] val);
            case (idx)
                REG_KERNEL_TOP: begin
                    for (int j = 0; j < 3; j++) coef[0][j] = val[COEF_BITS*j +: COEF_BITS];
                end
                REG_KERNEL_MID: begin
                    for (int j = 0; j < 3; j++) coef[1][j] = val[COEF_BITS*j +: COEF_BITS];
                end
                REG_KERNEL_BOTTOM: begin
                    for (int j = 0; j < 3; j++) coef[2][j] = val[COEF_BITS*j +: COEF_BITS];
                end
                REG_LINE_WIDTH:   width_reg  = val[WIDTH_BITS-1:0];
                REG_FRAME_HEIGHT: height_reg = val[HEIGHT_BITS-1:0];
                default: ;
            endcase
        endfunction

        // One accepted pixel: update line stores and window, queue a sum if the window is full
        function void take_pixel(input pix_t px, input bit frame_start);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            pix_t        up;
            pix_t        lo;
            bit          eol;
            bit          eof;
            longint      acc;
            result_t     res;
            w = eff_width();
            h = eff_height();
            if (frame_start) begin
                col_cnt = 0;
                row_cnt = 0;
            end
            c = (col_cnt >= w) ? w - 1 : col_cnt;
            r = row_cnt;
            up = upper_line[c];
            lo = lower_line[c];
            upper_line[c] = lo;
            lower_line[c] = px;
            for (int i = 0; i < 3; i++) begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[0][2] = up;
            win[1][2] = lo;
            win[2][2] = px;
            eol = (c >= w - 1);
            eof = eol && (r >= h - 1);
            if (r >= 2 && c >= 2) begin
                acc = 0;
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        acc += longint'(coef[i][j]) * longint'(win[i][j]);
                res.sum  = acc[SUM_BITS-1:0];
                res.last = eof;
                sums_due.push_back(res);
            end
            if (eof) begin
                col_cnt = 0;
                row_cnt = 0;
            end else if (eol) begin
                col_cnt = 0;
                row_cnt = r + 1;
            end else begin
                col_cnt = c + 1;
                row_cnt = r;
            end
        endfunction

        // One accepted result beat against the oldest queued sum
        function void check_sum(input logic [MDATA_BITS-1:0] data, input logic last);
            result_t want;
            if (sums_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result beat: expected none, actual sum %0d last %0b",
                             $time, $signed(data[SUM_BITS-1:0]), last);
                return;
            end
            want = sums_due.pop_front();
            if (data[SUM_BITS-1:0] !== want.sum) begin
                errors++;
                // keep the log readable if the block is badly broken
                if (errors <= MAX_REPORTS)
                    $display("%0t: window_sum mismatch: expected %0d actual %0d",
                             $time, want.sum, $signed(data[SUM_BITS-1:0]));
            end
            if (last !== want.last) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: last_of_frame mismatch: expected %0b actual %0b",
                             $time, want.last, last);
            end
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wen = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [KROW_BITS-1:0]     cfg_wdata = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [SDATA_BITS-1:0]    s_tdata = '0;   // [15:0] pixel
    logic                     s_tuser = 1'b0; // [0] frame_start
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [MDATA_BITS-1:0]    m_tdata;        // [35:0] window_sum, rest zero
    logic                     m_tlast;

    conv_window_tracker pred;
    int                 src_idle_pct = 0;
    int                 sink_stall_pct = 0;
    int unsigned        stim_count = 0;
    int unsigned        phase_base;
    int                 quiet_cycles = 0;
    int                 idle_plan [4] = '{0, 66, 0, 17};
    int                 stall_plan [4] = '{0, 0, 66, 17};

    conv3x3_stream u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side backpressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Result checking and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) pred.check_sum(m_tdata, m_tlast);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d sums outstanding", $time,
                         pred.sums_due.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic pix_t rand_pixel();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return pix_t'($urandom);
        endcase
    endfunction

    function automatic logic [KROW_BITS-1:0] rand_kernel_row();
        logic [KROW_BITS-1:0] kr;
        for (int j = 0; j < 3; j++) begin
            case ($urandom_range(7))
                0:       kr[COEF_BITS*j +: COEF_BITS] = 16'h8000;
                1:       kr[COEF_BITS*j +: COEF_BITS] = 16'h7FFF;
                2:       kr[COEF_BITS*j +: COEF_BITS] = '0;
                default: kr[COEF_BITS*j +: COEF_BITS] = COEF_BITS'($urandom);
            endcase
        end
        return kr;
    endfunction

    // Register write; called at a falling edge, returns at a falling edge
    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                             input logic [KROW_BITS-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        pred.set_reg(idx, val);
        @(negedge aclk);
        cfg_wen <= 1'b0;
        @(negedge aclk);
    endtask

    // One pixel beat, with random idle cycles ahead of it; valid stays high on return
    task automatic push_pixel(input pix_t px, input bit frame_start);
        bit taken;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= frame_start;
        taken = 1'b0;
        while (!taken) begin
            @(posedge aclk);
            taken = s_tready;
            if (taken) pred.take_pixel(px, frame_start);
            @(negedge aclk);
        end
        stim_count++;
    endtask

    // Stop sending, wait for every owed sum, then let the pipeline empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pred.sums_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic load_random_kernel();
        write_reg(REG_KERNEL_TOP, rand_kernel_row());
        write_reg(REG_KERNEL_MID, rand_kernel_row());
        write_reg(REG_KERNEL_BOTTOM, rand_kernel_row());
    endtask

    // One frame of random pixels; may be cut short, may change geometry partway through
    task automatic stream_frame(input bit abort, input bit reshape);
        int unsigned total;
        int unsigned n;
        int unsigned stop_at;
        int unsigned change_at;
        bit          lead_flag;
        lead_flag = !(pred.col_cnt == 0 && pred.row_cnt == 0) || ($urandom_range(3) != 0);
        total     = pred.eff_width() * pred.eff_height();
        stop_at   = $urandom_range(1, total - 1);
        change_at = $urandom_range(1, total - 1);
        n = 0;
        do begin
            if (reshape && n == change_at) begin
                // only narrowing is safe mid-frame; height may go either way
                drain_results();
                write_reg(REG_LINE_WIDTH, $urandom_range(3, pred.eff_width()));
                write_reg(REG_FRAME_HEIGHT, $urandom_range(3, 8));
            end
            push_pixel(rand_pixel(), lead_flag && n == 0);
            n++;
        end while (!(pred.col_cnt == 0 && pred.row_cnt == 0) && !(abort && n == stop_at));
    endtask

    initial begin
        pred = new();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Smallest frame through below-range geometry, largest positive sum
        write_reg(REG_LINE_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 2);
        write_reg(REG_KERNEL_TOP, {3{16'h8000}});
        write_reg(REG_KERNEL_MID, {3{16'h8000}});
        write_reg(REG_KERNEL_BOTTOM, {3{16'h8000}});
        for (int k = 0; k < 9; k++) push_pixel(16'sh8000, k == 0);
        // next frame follows by wraparound alone, most negative sum
        for (int k = 0; k < 9; k++) push_pixel(16'sh7FFF, 1'b0);

        // Kernel orientation: a distinct coefficient on every tap
        drain_results();
        write_reg(REG_KERNEL_TOP, {16'sd3, 16'sd2, 16'sd1});
        write_reg(REG_KERNEL_MID, {-16'sd11, 16'sd7, -16'sd5});
        write_reg(REG_KERNEL_BOTTOM, {16'sd19, -16'sd17, 16'sd13});
        write_reg(REG_LINE_WIDTH, 1);
        write_reg(REG_FRAME_HEIGHT, 0);
        for (int k = 0; k < 9; k++) push_pixel(pix_t'((k + 1) * 37 - 200), k == 0);

        // Random frames under each flow-control mix
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   = idle_plan[ph];
            sink_stall_pct = stall_plan[ph];
            phase_base     = stim_count;
            while (stim_count - phase_base < PHASE_ITEMS) begin
                drain_results();
                load_random_kernel();
                write_reg(REG_LINE_WIDTH, ($urandom_range(9) == 0) ?
                          $urandom_range(2) : $urandom_range(3, 12));
                write_reg(REG_FRAME_HEIGHT, ($urandom_range(9) == 0) ?
                          $urandom_range(2) : $urandom_range(3, 7));
                repeat ($urandom_range(1, 3))
                    stream_frame($urandom_range(9) == 0, $urandom_range(9) == 0);
            end
        end

        // Wind down
        s_tvalid <= 1'b0;
        while (pred.sums_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (pred.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
